[design/pol_pkg.sv]
// Shared types and codes for the positional ordered list.
package pol_pkg;

    localparam int POS_W  = 5;
    localparam int IDX_W  = 5;
    localparam int DATA_W = 32;

    // Operation codes of an input item
    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_SEARCH = 2'd2,
        KIND_READ   = 2'd3
    } kind_t;

    // Result status codes
    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_INVALID  = 3'd1,
        STAT_RANGE    = 3'd2,
        STAT_FULL     = 3'd3,
        STAT_NOTFOUND = 3'd4
    } status_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_INS_SHIFT,
        ST_INS_PUT,
        ST_DEL_SHIFT,
        ST_SRCH,
        ST_RD_ISSUE,
        ST_RD_EMIT,
        ST_RESP
    } state_t;

    // One result item handed from the sequencer to the output register
    typedef struct packed {
        status_t                   status;
        logic signed [DATA_W-1:0]  element;
        logic [IDX_W-1:0]          index;
        logic                      last;
    } res_t;

endpackage

[design/pol_mem.sv]
// Entry store: one write port, one read port with registered read data.
module pol_mem
    import pol_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/pol_ctrl.sv]
// Sequencer: walks the entry store one step a cycle per list operation, holding while the output register is full.
module pol_ctrl
    import pol_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int AW       = 4,
    parameter int CW       = 5
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               kind,
    input  logic [POS_W-1:0]         position,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     buf_free,
    output logic                     res_push,
    output res_t                     res,
    output logic                     mem_we,
    output logic [AW-1:0]            mem_waddr,
    output logic [DATA_W-1:0]        mem_wdata,
    output logic                     mem_re,
    output logic [AW-1:0]            mem_raddr,
    input  logic [DATA_W-1:0]        mem_rdata
);

    // compare width covering both the count and a position
    localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

    state_t              state_reg, state_next;
    kind_t               kind_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [DATA_W-1:0]   val_reg;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [CW-1:0]       j_reg, j_next;
    logic                pend_reg, pend_next;
    logic [AW-1:0]       waddr_reg, waddr_next;
    status_t             stat_reg, stat_next;
    logic [DATA_W-1:0]   elem_reg, elem_next;

    logic [XW-1:0]       pos_x, cnt_x, j_x, pm1_x;
    logic [CW-1:0]       jp1, jm1;
    logic                pos_zero, is_full, ins_range, del_range;
    logic                ins_more, del_more, srch_hit, j_below, rd_last;

    // shared compare terms
    assign pos_x     = XW'(pos_reg);
    assign cnt_x     = XW'(cnt_reg);
    assign j_x       = XW'(j_reg);
    assign pm1_x     = pos_x - XW'(1);
    assign jp1       = j_reg + CW'(1);
    assign jm1       = j_reg - CW'(1);
    assign pos_zero  = (pos_reg == '0);
    assign is_full   = (cnt_x >= XW'(CAPACITY));
    assign ins_range = (pos_x > cnt_x + XW'(1));
    assign del_range = (pos_x > cnt_x);
    assign ins_more  = (j_x != pm1_x);
    assign del_more  = (j_x + XW'(1) < cnt_x);
    assign srch_hit  = pend_reg && (mem_rdata == val_reg);
    assign j_below   = (j_x < cnt_x);
    assign rd_last   = (j_x + XW'(1) == cnt_x);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                unique case (kind_reg)
                    KIND_INSERT:
                    begin
                        state_next = (pos_zero || is_full || ins_range) ? ST_RESP
                                                                        : ST_INS_SHIFT;
                    end
                    KIND_DELETE:
                    begin
                        state_next = (pos_zero || del_range) ? ST_RESP : ST_DEL_SHIFT;
                    end
                    KIND_SEARCH: state_next = ST_SRCH;
                    KIND_READ:   state_next = ST_RD_ISSUE;
                    default:     state_next = ST_IDLE;
                endcase
            end
            ST_INS_SHIFT:
            begin
                if (!ins_more)
                begin
                    state_next = ST_INS_PUT;
                end
            end
            ST_INS_PUT: state_next = ST_RESP;
            ST_DEL_SHIFT:
            begin
                if (!del_more)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_SRCH:
            begin
                if (srch_hit || !j_below)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RD_ISSUE:
            begin
                state_next = j_below ? ST_RD_EMIT : ST_IDLE;
            end
            ST_RD_EMIT:
            begin
                if (buf_free && rd_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RESP:
            begin
                if (buf_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath controls and outputs
    always_comb
    begin
        in_ready    = (state_reg == ST_IDLE);
        mem_we      = 1'b0;
        mem_waddr   = waddr_reg;
        mem_wdata   = mem_rdata;
        mem_re      = 1'b0;
        mem_raddr   = j_reg[AW-1:0];
        j_next      = j_reg;
        pend_next   = 1'b0;
        waddr_next  = waddr_reg;
        cnt_next    = cnt_reg;
        stat_next   = stat_reg;
        elem_next   = elem_reg;
        res_push    = 1'b0;
        res.status  = stat_reg;
        res.element = elem_reg;
        res.index   = '0;
        res.last    = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_DECIDE:
            begin
                elem_next = '0;
                j_next    = '0;
                unique case (kind_reg)
                    KIND_INSERT:
                    begin
                        j_next = cnt_reg;
                        if (pos_zero)
                        begin
                            stat_next = STAT_INVALID;
                        end
                        else if (is_full)
                        begin
                            stat_next = STAT_FULL;
                        end
                        else if (ins_range)
                        begin
                            stat_next = STAT_RANGE;
                        end
                        else
                        begin
                            stat_next = STAT_OK;
                        end
                    end
                    KIND_DELETE:
                    begin
                        j_next = pm1_x[CW-1:0];
                        if (pos_zero)
                        begin
                            stat_next = STAT_INVALID;
                        end
                        else if (del_range)
                        begin
                            stat_next = STAT_RANGE;
                        end
                        else
                        begin
                            stat_next = STAT_OK;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            // move entries up, top down: read j-1, write j next cycle
            ST_INS_SHIFT:
            begin
                mem_we = pend_reg;
                if (ins_more)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = jm1[AW-1:0];
                    waddr_next = j_reg[AW-1:0];
                    j_next     = jm1;
                    pend_next  = 1'b1;
                end
            end
            // drop the new value into the opened slot
            ST_INS_PUT:
            begin
                mem_we    = 1'b1;
                mem_waddr = pm1_x[AW-1:0];
                mem_wdata = val_reg;
                cnt_next  = cnt_reg + CW'(1);
            end
            // close the gap, bottom up: read j+1, write j next cycle
            ST_DEL_SHIFT:
            begin
                mem_we = pend_reg;
                if (del_more)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = jp1[AW-1:0];
                    waddr_next = j_reg[AW-1:0];
                    j_next     = jp1;
                    pend_next  = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            // compare the entry read last cycle while reading the next
            ST_SRCH:
            begin
                if (srch_hit)
                begin
                    stat_next = STAT_OK;
                    elem_next = val_reg;
                end
                else if (j_below)
                begin
                    mem_re    = 1'b1;
                    j_next    = jp1;
                    pend_next = 1'b1;
                end
                else
                begin
                    stat_next = STAT_NOTFOUND;
                    elem_next = '0;
                end
            end
            ST_RD_ISSUE:
            begin
                mem_re = j_below;
            end
            // one item per cycle while the output register has room
            ST_RD_EMIT:
            begin
                res.status  = STAT_OK;
                res.element = mem_rdata;
                res.index   = IDX_W'(jp1);
                res.last    = rd_last;
                if (buf_free)
                begin
                    res_push = 1'b1;
                    j_next   = jp1;
                    if (!rd_last)
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = jp1[AW-1:0];
                    end
                end
            end
            ST_RESP:
            begin
                res_push = buf_free;
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            kind_reg <= kind_t'(kind);
            pos_reg  <= position;
            val_reg  <= value;
        end
        j_reg     <= j_next;
        waddr_reg <= waddr_next;
        stat_reg  <= stat_next;
        elem_reg  <= elem_next;
    end

endmodule

[design/positional_ordered_list_top.sv]
// Bounded positional ordered list: sequencer, entry store and output register.
// Insert and delete shift entries, search compares them, all through the single read
// and write port of the entry store, one entry moved or compared a cycle; read-out
// emits one item per cycle while the output register has room.
// One item in flight at a time.
// Reset clears the count and the control state; entries are not cleared.
module positional_ordered_list_top
    import pol_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               kind,
    input  logic [POS_W-1:0]         position,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [2:0]               status,
    output logic signed [DATA_W-1:0] element,
    output logic [IDX_W-1:0]         index,
    output logic                     last
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic              buf_free;
    logic              res_push;
    res_t              res;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [DATA_W-1:0] mem_rdata;

    logic              out_valid_reg;
    res_t              out_reg;

    pol_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .position  (position),
        .value     (value),
        .buf_free  (buf_free),
        .res_push  (res_push),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    pol_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // output register: takes a new item when empty or being drained
    assign buf_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (buf_free)
        begin
            out_valid_reg <= res_push;
        end
    end

    always_ff @(posedge clk)
    begin
        if (buf_free && res_push)
        begin
            out_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_reg.status;
    assign element   = out_reg.element;
    assign index     = out_reg.index;
    assign last      = out_reg.last;

endmodule
